// ===== design/shq_pkg.sv =====
// ----------------------------------------------------------------------------
// shq_pkg
// Shared constants, types and the cell hash of the spatial hash neighbor query.
// ----------------------------------------------------------------------------
package shq_pkg;

    localparam int MAX_OBJECTS = 32;
    localparam int TABLE_CELLS = 64;
    localparam int MAX_SPAN    = 3;
    localparam int RESULT_CAP  = 64;

    localparam logic [31:0] HASH_PX = 32'd92837111;
    localparam logic [31:0] HASH_PY = 32'd689287499;
    localparam logic [31:0] HASH_PZ = 32'd283923481;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 6;
    localparam int POS_W   = 21;
    localparam int RAD_W   = 20;
    localparam int INV_W   = 16;
    localparam int ID_W    = 5;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 2;

    localparam int COORD_W   = POS_W + 1;
    localparam int PROD_W    = COORD_W + INV_W + 1;
    localparam int FRAC_W    = 16;
    localparam int FRAC_MASK = (2 ** FRAC_W) - 1;
    localparam int CELL_W    = PROD_W - FRAC_W;

    localparam int TB_W   = $clog2(TABLE_CELLS);
    localparam int BAW    = $clog2(TABLE_CELLS + 1);
    localparam int EAW    = $clog2(MAX_OBJECTS);
    localparam int RAW    = $clog2(RESULT_CAP);
    localparam int CNT_W  = $clog2(RESULT_CAP + 1);
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int CONV_W = 3;
    localparam int CONV_STEPS = 6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_INV_SPACING = 1'b0;
    localparam logic REG_IS_3D       = 1'b1;
    localparam logic [INV_W-1:0] INV_RESET = 16'd256;

    typedef enum logic [OP_W-1:0] {
        OP_BUCKET = 2'd0,
        OP_ENTRY  = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_CONV  = 11'b000_0000_0010,
        ST_CLIP  = 11'b000_0000_0100,
        ST_BKS   = 11'b000_0000_1000,
        ST_BKE   = 11'b000_0001_0000,
        ST_BKW   = 11'b000_0010_0000,
        ST_ENT   = 11'b000_0100_0000,
        ST_ENTW  = 11'b000_1000_0000,
        ST_NEXT  = 11'b001_0000_0000,
        ST_EMRD  = 11'b010_0000_0000,
        ST_EMLD  = 11'b100_0000_0000
    } state_t;

    // hash mod a power-of-two table only needs the low bits of each product
    function automatic logic [TB_W-1:0] cell_hash(input logic [TB_W-1:0] x,
                                                  input logic [TB_W-1:0] y,
                                                  input logic [TB_W-1:0] z);
        logic [TB_W-1:0] px;
        logic [TB_W-1:0] py;
        logic [TB_W-1:0] pz;
        px = x * HASH_PX[TB_W-1:0];
        py = y * HASH_PY[TB_W-1:0];
        pz = z * HASH_PZ[TB_W-1:0];
        return px ^ py ^ pz;
    endfunction

endpackage

// ===== design/spatial_hash_neighbor_query.sv =====
// ----------------------------------------------------------------------------
// spatial_hash_neighbor_query
// Spatial hash grid: loads bucket and entry tables, answers box queries.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per command. s_tuser is the opcode: bucket
// start write, entry write or query. Writes return a single ack word.
// A query returns every object id from the buckets of the cells that
// pos +/- max_dist covers (at most 3 cells per axis, 64 ids), then last.
// overflow is flagged on every word of a clipped query; an empty query
// returns one word with found=0.
// Output stream (m_*): registered; a stalled receiver holds the block.
// Timing: a write is acked the cycle after acceptance. A query takes
// 6 multiplies on one shared multiplier, a clip step, then the bucket
// reads per cell, an entry read and result write per found id, a close
// of the range and a step per cell, and a read and load per emitted word; one query at a
// time, s_tready is low until its last word is loaded.
// Reset: inv_spacing=1.0, is_3d=1. Table contents are undefined until
// written and no clearing pass runs. Configure only while idle (APB).
// ----------------------------------------------------------------------------
module spatial_hash_neighbor_query (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: index[6:0], value[12:7], pos_x[33:13], pos_y[54:34],
    //          pos_z[75:55], max_dist[95:76]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [shq_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [shq_pkg::OP_W-1:0]          s_tuser,     // op[1:0]
    // m_tdata: object_id[4:0], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [shq_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [shq_pkg::M_USER_W-1:0]      m_tuser,     // found[0], overflow[1]
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shq_pkg::PADDR_W-1:0]       paddr,
    input  logic [shq_pkg::PDATA_W-1:0]       pwdata,
    output logic [shq_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    // ---------------- input fields ----------------
    logic [shq_pkg::IDX_W-1:0]        in_index;
    logic [shq_pkg::VAL_W-1:0]        in_value;
    logic signed [shq_pkg::POS_W-1:0] in_pos [3];
    logic [shq_pkg::RAD_W-1:0]        in_rad;

    assign in_index  = s_tdata[6:0];
    assign in_value  = s_tdata[12:7];
    assign in_pos[0] = s_tdata[33:13];
    assign in_pos[1] = s_tdata[54:34];
    assign in_pos[2] = s_tdata[75:55];
    assign in_rad    = s_tdata[95:76];

    // ---------------- configuration ----------------
    logic [shq_pkg::INV_W-1:0] inv_reg;
    logic                      is3d_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[shq_pkg::PADDR_W-1] == shq_pkg::REG_IS_3D) ?
                    {{(shq_pkg::PDATA_W-1){1'b0}}, is3d_reg} :
                    {{(shq_pkg::PDATA_W-shq_pkg::INV_W){1'b0}}, inv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg  <= shq_pkg::INV_RESET;
            is3d_reg <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[shq_pkg::PADDR_W-1] == shq_pkg::REG_INV_SPACING) begin
                inv_reg <= pwdata[shq_pkg::INV_W-1:0];
            end else begin
                is3d_reg <= pwdata[0];
            end
        end
    end

    // ---------------- registers ----------------
    shq_pkg::state_t                   state_reg, state_next;
    logic [shq_pkg::CONV_W-1:0]        cnt_reg, cnt_next;
    logic signed [shq_pkg::POS_W-1:0]  pos_reg [3];
    logic signed [shq_pkg::POS_W-1:0]  pos_next [3];
    logic [shq_pkg::RAD_W-1:0]         rad_reg, rad_next;
    logic signed [shq_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [shq_pkg::CELL_W-1:0] lo_reg [3];
    logic signed [shq_pkg::CELL_W-1:0] lo_next [3];
    logic signed [shq_pkg::CELL_W-1:0] hi_reg [3];
    logic signed [shq_pkg::CELL_W-1:0] hi_next [3];
    logic [shq_pkg::SPAN_W-1:0]        span_reg [3];
    logic [shq_pkg::SPAN_W-1:0]        span_next [3];
    logic [shq_pkg::TB_W-1:0]          base_reg [3];
    logic [shq_pkg::TB_W-1:0]          base_next [3];
    logic [shq_pkg::SPAN_W-1:0]        idx_reg [3];
    logic [shq_pkg::SPAN_W-1:0]        idx_next [3];
    logic [shq_pkg::TB_W-1:0]          h_reg, h_next;
    logic                              ovf_reg, ovf_next;
    logic [shq_pkg::VAL_W-1:0]         start_reg, start_next;
    logic [shq_pkg::VAL_W-1:0]         end_reg, end_next;
    logic [shq_pkg::VAL_W-1:0]         l_reg, l_next;
    logic [shq_pkg::CNT_W-1:0]         n_reg, n_next;
    logic [shq_pkg::RAW-1:0]           e_reg, e_next;
    logic                              mv_reg, mv_next;
    logic [shq_pkg::ID_W-1:0]          mid_reg, mid_next;
    logic                              mfound_reg, mfound_next;
    logic                              movf_reg, movf_next;
    logic                              mlast_reg, mlast_next;

    // ---------------- memories ----------------
    logic                         bk_we;
    logic [shq_pkg::BAW-1:0]      bk_raddr;
    logic [shq_pkg::VAL_W-1:0]    bk_rdata;
    logic                         en_we;
    logic [shq_pkg::ID_W-1:0]     en_rdata;
    logic                         rb_we;
    logic [shq_pkg::ID_W-1:0]     rb_rdata;
    logic                         accept;
    logic                         out_free;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == shq_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign bk_we = accept && (s_tuser == shq_pkg::OP_BUCKET) &&
                   (in_index <= shq_pkg::IDX_W'(shq_pkg::TABLE_CELLS));
    assign en_we = accept && (s_tuser == shq_pkg::OP_ENTRY) &&
                   (in_index < shq_pkg::IDX_W'(shq_pkg::MAX_OBJECTS));
    assign rb_we = (state_reg == shq_pkg::ST_ENTW);

    // ---------------- datapath helpers ----------------
    logic [1:0]                        conv_axis;
    logic [shq_pkg::CONV_W-1:0]        conv_prev;
    logic signed [shq_pkg::COORD_W-1:0] coord;
    logic signed [shq_pkg::PROD_W-1:0] prod_adj;
    logic signed [shq_pkg::CELL_W-1:0] cell_val;
    logic [shq_pkg::TB_W-1:0]          hash_now;
    logic signed [shq_pkg::CELL_W:0]   diff [3];
    logic                              ent_ok;

    assign conv_axis = cnt_reg[2:1];
    assign conv_prev = cnt_reg - 1'b1;

    always_comb begin
        if (cnt_reg[0]) begin
            coord = shq_pkg::COORD_W'(pos_reg[conv_axis]) +
                    $signed({2'b00, rad_reg});
        end else begin
            coord = shq_pkg::COORD_W'(pos_reg[conv_axis]) -
                    $signed({2'b00, rad_reg});
        end
    end

    // truncate toward zero: bias negative products before the shift
    assign prod_adj = prod_reg + (prod_reg[shq_pkg::PROD_W-1] ?
                      shq_pkg::PROD_W'(shq_pkg::FRAC_MASK) : '0);
    assign cell_val = prod_adj[shq_pkg::PROD_W-1:shq_pkg::FRAC_W];

    assign hash_now = shq_pkg::cell_hash(
        base_reg[0] + shq_pkg::TB_W'(idx_reg[0]),
        base_reg[1] + shq_pkg::TB_W'(idx_reg[1]),
        base_reg[2] + shq_pkg::TB_W'(idx_reg[2]));

    assign bk_raddr = (state_reg == shq_pkg::ST_BKS) ? shq_pkg::BAW'(hash_now) :
                      shq_pkg::BAW'(h_reg) + 1'b1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (a == 2 && !is3d_reg) begin
                diff[a] = '0;
            end else begin
                diff[a] = {hi_reg[a][shq_pkg::CELL_W-1], hi_reg[a]} -
                          {lo_reg[a][shq_pkg::CELL_W-1], lo_reg[a]};
            end
        end
    end

    assign ent_ok = (l_reg < end_reg) &&
                    ({1'b0, l_reg} < (shq_pkg::VAL_W+1)'(shq_pkg::MAX_OBJECTS));

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        rad_next    = rad_reg;
        prod_next   = prod_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        span_next   = span_reg;
        base_next   = base_reg;
        idx_next    = idx_reg;
        h_next      = h_reg;
        ovf_next    = ovf_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        l_next      = l_reg;
        n_next      = n_reg;
        e_next      = e_reg;
        mv_next     = mv_reg && !m_tready;
        mid_next    = mid_reg;
        mfound_next = mfound_reg;
        movf_next   = movf_reg;
        mlast_next  = mlast_reg;

        case (state_reg)
            shq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == shq_pkg::OP_QUERY) begin
                        pos_next   = in_pos;
                        rad_next   = in_rad;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        n_next     = '0;
                        e_next     = '0;
                        state_next = shq_pkg::ST_CONV;
                    end else begin
                        mv_next     = 1'b1;
                        mid_next    = '0;
                        mfound_next = 1'b0;
                        movf_next   = 1'b0;
                        mlast_next  = 1'b1;
                    end
                end
            end
            shq_pkg::ST_CONV: begin
                if (cnt_reg < shq_pkg::CONV_W'(shq_pkg::CONV_STEPS)) begin
                    prod_next = $signed(coord) * $signed({1'b0, inv_reg});
                end
                if (cnt_reg != '0) begin
                    if (conv_prev[0]) begin
                        hi_next[conv_prev[2:1]] = cell_val;
                    end else begin
                        lo_next[conv_prev[2:1]] = cell_val;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == shq_pkg::CONV_W'(shq_pkg::CONV_STEPS)) begin
                    state_next = shq_pkg::ST_CLIP;
                end
            end
            shq_pkg::ST_CLIP: begin
                for (int a = 0; a < 3; a++) begin
                    idx_next[a]  = '0;
                    base_next[a] = (a == 2 && !is3d_reg) ? '0 :
                                   lo_reg[a][shq_pkg::TB_W-1:0];
                    if (diff[a][shq_pkg::CELL_W]) begin
                        span_next[a] = shq_pkg::SPAN_W'(1);
                    end else if (diff[a] >= (shq_pkg::CELL_W+1)'(shq_pkg::MAX_SPAN)) begin
                        span_next[a] = shq_pkg::SPAN_W'(shq_pkg::MAX_SPAN);
                        ovf_next     = 1'b1;
                    end else begin
                        span_next[a] = diff[a][shq_pkg::SPAN_W-1:0] + 1'b1;
                    end
                end
                state_next = shq_pkg::ST_BKS;
            end
            shq_pkg::ST_BKS: begin
                h_next     = hash_now;
                state_next = shq_pkg::ST_BKE;
            end
            shq_pkg::ST_BKE: begin
                start_next = bk_rdata;
                state_next = shq_pkg::ST_BKW;
            end
            shq_pkg::ST_BKW: begin
                end_next   = bk_rdata;
                l_next     = start_reg;
                state_next = shq_pkg::ST_ENT;
            end
            shq_pkg::ST_ENT: begin
                if (!ent_ok) begin
                    state_next = shq_pkg::ST_NEXT;
                end else if (n_reg == shq_pkg::CNT_W'(shq_pkg::RESULT_CAP)) begin
                    ovf_next   = 1'b1;
                    state_next = shq_pkg::ST_EMRD;
                end else begin
                    l_next     = l_reg + 1'b1;
                    state_next = shq_pkg::ST_ENTW;
                end
            end
            shq_pkg::ST_ENTW: begin
                n_next     = n_reg + 1'b1;
                state_next = shq_pkg::ST_ENT;
            end
            shq_pkg::ST_NEXT: begin
                state_next = shq_pkg::ST_BKS;
                if (idx_reg[2] + 1'b1 < span_reg[2]) begin
                    idx_next[2] = idx_reg[2] + 1'b1;
                end else begin
                    idx_next[2] = '0;
                    if (idx_reg[1] + 1'b1 < span_reg[1]) begin
                        idx_next[1] = idx_reg[1] + 1'b1;
                    end else begin
                        idx_next[1] = '0;
                        if (idx_reg[0] + 1'b1 < span_reg[0]) begin
                            idx_next[0] = idx_reg[0] + 1'b1;
                        end else begin
                            state_next = shq_pkg::ST_EMRD;
                        end
                    end
                end
            end
            shq_pkg::ST_EMRD: begin
                if (out_free) begin
                    if (n_reg == '0) begin
                        mv_next     = 1'b1;
                        mid_next    = '0;
                        mfound_next = 1'b0;
                        movf_next   = ovf_reg;
                        mlast_next  = 1'b1;
                        state_next  = shq_pkg::ST_IDLE;
                    end else begin
                        state_next = shq_pkg::ST_EMLD;
                    end
                end
            end
            shq_pkg::ST_EMLD: begin
                mv_next     = 1'b1;
                mid_next    = rb_rdata;
                mfound_next = 1'b1;
                movf_next   = ovf_reg;
                mlast_next  = (shq_pkg::CNT_W'(e_reg) + 1'b1 == n_reg);
                e_next      = e_reg + 1'b1;
                state_next  = mlast_next ? shq_pkg::ST_IDLE : shq_pkg::ST_EMRD;
            end
            default: begin
                state_next = shq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shq_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            e_reg     <= '0;
            idx_reg   <= '{default: '0};
            span_reg  <= '{default: '0};
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            e_reg     <= e_next;
            idx_reg   <= idx_next;
            span_reg  <= span_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        rad_reg    <= rad_next;
        prod_reg   <= prod_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        base_reg   <= base_next;
        h_reg      <= h_next;
        ovf_reg    <= ovf_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        l_reg      <= l_next;
        mid_reg    <= mid_next;
        mfound_reg <= mfound_next;
        movf_reg   <= movf_next;
        mlast_reg  <= mlast_next;
    end

    shq_ram #(.WIDTH(shq_pkg::VAL_W), .DEPTH(shq_pkg::TABLE_CELLS + 1)) u_bucket_ram (
        .aclk  (aclk),
        .we    (bk_we),
        .waddr (in_index[shq_pkg::BAW-1:0]),
        .wdata (in_value),
        .raddr (bk_raddr),
        .rdata (bk_rdata)
    );

    shq_ram #(.WIDTH(shq_pkg::ID_W), .DEPTH(shq_pkg::MAX_OBJECTS)) u_entry_ram (
        .aclk  (aclk),
        .we    (en_we),
        .waddr (in_index[shq_pkg::EAW-1:0]),
        .wdata (in_value[shq_pkg::ID_W-1:0]),
        .raddr (l_reg[shq_pkg::EAW-1:0]),
        .rdata (en_rdata)
    );

    shq_ram #(.WIDTH(shq_pkg::ID_W), .DEPTH(shq_pkg::RESULT_CAP)) u_result_ram (
        .aclk  (aclk),
        .we    (rb_we),
        .waddr (n_reg[shq_pkg::RAW-1:0]),
        .wdata (en_rdata),
        .raddr (e_reg),
        .rdata (rb_rdata)
    );

    // ---------------- outputs ----------------
    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(shq_pkg::M_DATA_W-shq_pkg::ID_W){1'b0}}, mid_reg};
    assign m_tuser  = {movf_reg, mfound_reg};
    assign m_tlast  = mlast_reg;

    // ---------------- assertions ----------------
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= shq_pkg::CNT_W'(shq_pkg::RESULT_CAP))
        else $error("result count above cap");

    a_buf_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == shq_pkg::ST_ENTW |-> n_reg < shq_pkg::CNT_W'(shq_pkg::RESULT_CAP))
        else $error("result buffer written past cap");

    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == shq_pkg::ST_BKS |->
            (idx_reg[0] < span_reg[0]) && (idx_reg[1] < span_reg[1]) &&
            (idx_reg[2] < span_reg[2]))
        else $error("cell walk outside clipped box");

    a_notfound_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("word without object id is not last");

    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == shq_pkg::OP_QUERY) |=>
            state_reg == shq_pkg::ST_CONV)
        else $error("query did not start conversion");

endmodule

// ===== design/shq_ram.sv =====
// ----------------------------------------------------------------------------
// shq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/spatial_hash_neighbor_query_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_neighbor_query_test
// Self-checking bench for the spatial hash neighbor query block. Loads bucket
// and entry tables over the input stream, runs directed and random queries
// under several register settings, and compares every output word in order
// against a behavioral predictor. Both stream sides idle at random; one phase
// holds the output off long enough to back the block up.
// ----------------------------------------------------------------------------
module spatial_hash_neighbor_query_test;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_LEN    = 400;

    localparam logic [shq_pkg::OP_W-1:0]    OP_NONE  = 2'd3;
    localparam logic [shq_pkg::PADDR_W-1:0] ADDR_INV = {shq_pkg::REG_INV_SPACING, 2'b00};
    localparam logic [shq_pkg::PADDR_W-1:0] ADDR_3D  = {shq_pkg::REG_IS_3D, 2'b00};
    localparam logic [shq_pkg::POS_W-1:0]   POS_MIN  = 21'h100000;
    localparam logic [shq_pkg::POS_W-1:0]   POS_MAX  = 21'h0FFFFF;
    localparam logic [shq_pkg::RAD_W-1:0]   RAD_MAX  = 20'hFFFFF;

    typedef enum int {
        LAYOUT_SORTED,
        LAYOUT_SCRAMBLED,
        LAYOUT_ALTERNATING
    } layout_t;

    typedef struct packed {
        bit [shq_pkg::ID_W-1:0] object_id;
        bit                     found;
        bit                     overflow;
        bit                     last;
    } nbr_word_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [shq_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [shq_pkg::OP_W-1:0]     s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [shq_pkg::M_DATA_W-1:0] m_tdata;
    logic [shq_pkg::M_USER_W-1:0] m_tuser;
    logic                         m_tlast;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [shq_pkg::PADDR_W-1:0]  paddr    = '0;
    logic [shq_pkg::PDATA_W-1:0]  pwdata   = '0;
    logic [shq_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    bit [shq_pkg::VAL_W-1:0] bucket_mirror [0:shq_pkg::TABLE_CELLS];
    bit [shq_pkg::ID_W-1:0]  entry_mirror [0:shq_pkg::MAX_OBJECTS-1];
    bit [shq_pkg::INV_W-1:0] cur_inv = shq_pkg::INV_RESET;
    bit                      cur_3d  = 1'b1;

    nbr_word_t neighbor_words [$];
    int        errors       = 0;
    int        quiet_cycles = 0;
    int        hold_left    = 0;
    bit        no_idle      = 1'b0;
    bit        hold_req     = 1'b0;

    spatial_hash_neighbor_query DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // output side: random stalls, or a long hold when requested
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge aclk) begin : check_words
        nbr_word_t got;
        nbr_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[shq_pkg::ID_W-1:0], m_tuser[0], m_tuser[1], m_tlast};
            if (neighbor_words.size() == 0) begin
                errors++;
                $display({"%0t: unexpected word: expected none, actual id=%0d found=%0b ",
                          "ovf=%0b last=%0b"},
                         $time, got.object_id, got.found, got.overflow, got.last);
            end else begin
                want = neighbor_words.pop_front();
                if (got !== want) begin
                    errors++;
                    $display({"%0t: word mismatch: expected id=%0d found=%0b ovf=%0b ",
                              "last=%0b, actual id=%0d found=%0b ovf=%0b last=%0b"},
                             $time, want.object_id, want.found, want.overflow, want.last,
                             got.object_id, got.found, got.overflow, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("spatial_hash_neighbor_query verification failed");
            $finish;
        end
    end

    // Q12.8 coordinate times Q8.8 scale, truncated toward zero
    function automatic longint cell_index(input longint coord);
        longint prod;
        prod = coord * longint'(cur_inv);
        return prod / 65536;
    endfunction

    function automatic bit [shq_pkg::TB_W-1:0] bucket_of(input longint x, input longint y,
                                                         input longint z);
        bit [31:0] mix;
        mix = (x[31:0] * shq_pkg::HASH_PX) ^ (y[31:0] * shq_pkg::HASH_PY) ^
              (z[31:0] * shq_pkg::HASH_PZ);
        return shq_pkg::TB_W'(mix % shq_pkg::TABLE_CELLS);
    endfunction

    task automatic compute_neighbors(input logic [shq_pkg::OP_W-1:0] op,
                                     input logic [shq_pkg::IDX_W-1:0] idx,
                                     input logic [shq_pkg::VAL_W-1:0] val,
                                     input logic [shq_pkg::POS_W-1:0] px, py, pz,
                                     input logic [shq_pkg::RAD_W-1:0] rad);
        longint                           lo [3];
        longint                           hi [3];
        logic signed [shq_pkg::POS_W-1:0] pos [3];
        longint                           p, r, cx, cy, cz;
        nbr_word_t                        hits [$];
        nbr_word_t                        w;
        bit                               ovf;
        int                               a, l, s, e;
        bit [shq_pkg::TB_W-1:0]           h;

        ovf = 1'b0;
        w   = '0;
        if (op != shq_pkg::OP_QUERY) begin
            if (op == shq_pkg::OP_BUCKET && idx <= shq_pkg::TABLE_CELLS)
                bucket_mirror[idx] = val;
            if (op == shq_pkg::OP_ENTRY && idx < shq_pkg::MAX_OBJECTS)
                entry_mirror[idx] = val[shq_pkg::ID_W-1:0];
            w.last = 1'b1;
            neighbor_words.push_back(w);
            return;
        end

        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        r = longint'(rad);
        for (a = 0; a < 3; a++) begin
            p     = longint'(pos[a]);
            lo[a] = cell_index(p - r);
            hi[a] = cell_index(p + r);
        end
        if (!cur_3d) begin
            lo[2] = 0;
            hi[2] = 0;
        end
        for (a = 0; a < 3; a++) begin
            if (hi[a] < lo[a])
                hi[a] = lo[a];
            if (hi[a] - lo[a] + 1 > shq_pkg::MAX_SPAN) begin
                hi[a] = lo[a] + shq_pkg::MAX_SPAN - 1;
                ovf   = 1'b1;
            end
        end

        for (cx = lo[0]; cx <= hi[0]; cx++)
            for (cy = lo[1]; cy <= hi[1]; cy++)
                for (cz = lo[2]; cz <= hi[2]; cz++) begin
                    h = bucket_of(cx, cy, cz);
                    s = int'(bucket_mirror[h]);
                    e = int'(bucket_mirror[h + 1]);
                    for (l = s; l < e && l < shq_pkg::MAX_OBJECTS; l++) begin
                        if (hits.size() >= shq_pkg::RESULT_CAP) begin
                            ovf = 1'b1;
                            break;
                        end
                        w           = '0;
                        w.object_id = entry_mirror[l];
                        w.found     = 1'b1;
                        hits.push_back(w);
                    end
                end

        if (hits.size() == 0) begin
            w          = '0;
            w.overflow = ovf;
            w.last     = 1'b1;
            neighbor_words.push_back(w);
        end else begin
            for (a = 0; a < hits.size(); a++) begin
                w          = hits[a];
                w.overflow = ovf;
                w.last     = (a == hits.size() - 1);
                neighbor_words.push_back(w);
            end
        end
    endtask

    task automatic send_command(input logic [shq_pkg::OP_W-1:0] op,
                                input logic [shq_pkg::IDX_W-1:0] idx,
                                input logic [shq_pkg::VAL_W-1:0] val,
                                input logic [shq_pkg::POS_W-1:0] px, py, pz,
                                input logic [shq_pkg::RAD_W-1:0] rad);
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rad, pz, py, px, val, idx};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        compute_neighbors(op, idx, val, px, py, pz, rad);
    endtask

    task automatic send_query(input logic [shq_pkg::POS_W-1:0] px, py, pz,
                              input logic [shq_pkg::RAD_W-1:0] rad);
        send_command(shq_pkg::OP_QUERY, shq_pkg::IDX_W'($urandom), shq_pkg::VAL_W'($urandom),
                     px, py, pz, rad);
    endtask

    task automatic send_write(input logic [shq_pkg::OP_W-1:0] op,
                              input logic [shq_pkg::IDX_W-1:0] idx,
                              input logic [shq_pkg::VAL_W-1:0] val);
        send_command(op, idx, val, shq_pkg::POS_W'($urandom), shq_pkg::POS_W'($urandom),
                     shq_pkg::POS_W'($urandom), shq_pkg::RAD_W'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (neighbor_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [shq_pkg::PADDR_W-1:0] addr,
                             input logic [shq_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of the bus carry junk, the block keeps only the register width
    task automatic set_config(input bit [shq_pkg::INV_W-1:0] inv, input bit d3);
        logic [shq_pkg::PDATA_W-1:0] junk;
        junk = $urandom;
        reg_write(ADDR_INV, {junk[shq_pkg::PDATA_W-1:shq_pkg::INV_W], inv});
        reg_write(ADDR_3D, {junk[shq_pkg::PDATA_W-1:1], d3});
        cur_inv = inv;
        cur_3d  = d3;
    endtask

    task automatic load_tables(input layout_t layout);
        int i;
        int start;
        start = 0;
        for (i = 0; i <= shq_pkg::TABLE_CELLS; i++) begin
            case (layout)
                LAYOUT_SORTED: begin
                    send_write(shq_pkg::OP_BUCKET, shq_pkg::IDX_W'(i), shq_pkg::VAL_W'(start));
                    start = start + $urandom_range(0, 2);
                    if (start > shq_pkg::MAX_OBJECTS)
                        start = shq_pkg::MAX_OBJECTS;
                end
                LAYOUT_SCRAMBLED: send_write(shq_pkg::OP_BUCKET, shq_pkg::IDX_W'(i),
                                             shq_pkg::VAL_W'($urandom_range(0, 63)));
                default: send_write(shq_pkg::OP_BUCKET, shq_pkg::IDX_W'(i),
                                    shq_pkg::VAL_W'((i % 2) ? shq_pkg::MAX_OBJECTS : 0));
            endcase
        end
        for (i = 0; i < shq_pkg::MAX_OBJECTS; i++)
            send_write(shq_pkg::OP_ENTRY, shq_pkg::IDX_W'(i),
                       shq_pkg::VAL_W'($urandom_range(0, 63)));
    endtask

    function automatic logic [shq_pkg::POS_W-1:0] rand_pos();
        int v;
        if ($urandom_range(0, 1))
            v = $urandom;
        else
            v = int'($urandom_range(0, 8191)) - 4096;
        return v[shq_pkg::POS_W-1:0];
    endfunction

    function automatic logic [shq_pkg::RAD_W-1:0] rand_radius();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return shq_pkg::RAD_W'($urandom_range(0, 768));
        else if (sel < 85)
            return shq_pkg::RAD_W'($urandom_range(0, 4096));
        return shq_pkg::RAD_W'($urandom);
    endfunction

    task automatic random_commands(input int count);
        int sel;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 72)
                send_query(rand_pos(), rand_pos(), rand_pos(), rand_radius());
            else if (sel < 84)
                send_write(shq_pkg::OP_BUCKET,
                           shq_pkg::IDX_W'((sel < 82) ?
                                           $urandom_range(0, shq_pkg::TABLE_CELLS) : $urandom),
                           shq_pkg::VAL_W'($urandom));
            else if (sel < 96)
                send_write(shq_pkg::OP_ENTRY,
                           shq_pkg::IDX_W'((sel < 94) ?
                                           $urandom_range(0, shq_pkg::MAX_OBJECTS - 1) :
                                           $urandom),
                           shq_pkg::VAL_W'($urandom));
            else
                send_write(OP_NONE, shq_pkg::IDX_W'($urandom), shq_pkg::VAL_W'($urandom));
        end
    endtask

    task automatic test_table_writes();
        load_tables(LAYOUT_SORTED);
        send_write(shq_pkg::OP_BUCKET, shq_pkg::IDX_W'(shq_pkg::TABLE_CELLS + 1), 6'h3F);
        send_write(shq_pkg::OP_BUCKET, 7'h7F, 6'h15);
        send_write(shq_pkg::OP_ENTRY, shq_pkg::IDX_W'(shq_pkg::MAX_OBJECTS), 6'h2A);
        send_write(shq_pkg::OP_ENTRY, 7'h7F, 6'h3F);
        send_write(OP_NONE, 7'h55, 6'h2A);
        wait_idle();
    endtask

    task automatic test_directed_queries();
        set_config(shq_pkg::INV_RESET, 1'b1);
        // origin cell hashes to bucket 0
        send_write(shq_pkg::OP_BUCKET, 0, 5);
        send_write(shq_pkg::OP_BUCKET, 1, 5);
        send_query(0, 0, 0, 0);
        send_write(shq_pkg::OP_BUCKET, 1, 3);
        send_query(0, 0, 0, 0);
        // range runs past the end of the entry store
        send_write(shq_pkg::OP_BUCKET, 0, 30);
        send_write(shq_pkg::OP_BUCKET, 1, 40);
        send_query(0, 0, 0, 0);
        send_write(shq_pkg::OP_BUCKET, 0, 0);
        send_write(shq_pkg::OP_BUCKET, 1, 1);
        send_write(shq_pkg::OP_ENTRY, 0, 6'h3F);
        send_query(0, 0, 0, 0);
        send_query(-256, -256, -256, 0);
        send_query(-255, 255, -1, 0);
        send_query(256, 256, 256, 256);
        send_query(256, 256, 256, 512);
        send_query(POS_MIN, POS_MIN, POS_MIN, RAD_MAX);
        send_query(POS_MAX, POS_MAX, POS_MAX, RAD_MAX);
        send_query(POS_MAX, POS_MIN, 0, 0);
        wait_idle();
    endtask

    task automatic test_result_cap();
        load_tables(LAYOUT_ALTERNATING);
        repeat (6) send_query(rand_pos(), rand_pos(), rand_pos(), 512);
        send_query(0, 0, 0, 0);
        wait_idle();
        set_config(shq_pkg::INV_RESET, 1'b0);
        repeat (4) send_query(rand_pos(), rand_pos(), rand_pos(), 512);
        wait_idle();
    endtask

    task automatic test_output_stall();
        set_config(shq_pkg::INV_RESET, 1'b1);
        load_tables(LAYOUT_SCRAMBLED);
        hold_req = 1'b1;
        repeat (12) send_query(rand_pos(), rand_pos(), rand_pos(), rand_radius());
        wait_idle();
    endtask

    task automatic test_random_configs();
        int                      ph;
        bit [shq_pkg::INV_W-1:0] inv;
        bit                      d3;
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       begin inv = shq_pkg::INV_RESET; d3 = 1'b1; end
                1:       begin inv = '0;        d3 = 1'b1; end
                2:       begin inv = '1;        d3 = 1'b1; end
                3:       begin inv = 16'd128;   d3 = 1'b0; end
                4:       begin inv = '1;        d3 = 1'b0; end
                default: begin
                    inv = shq_pkg::INV_W'($urandom_range(64, 1024));
                    d3  = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(inv, d3);
            no_idle = (ph == 5);
            random_commands((ph == 5) ? 20 : 6);
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_writes();
        test_directed_queries();
        test_result_cap();
        test_output_stall();
        test_random_configs();
        repeat (40) @(posedge aclk);
        if (neighbor_words.size() != 0)
            errors++;
        if (errors == 0)
            $display("spatial_hash_neighbor_query verification clean");
        else
            $display("spatial_hash_neighbor_query verification failed");
        $finish;
    end

endmodule
